>>> rtl/tsf_pkg.sv
// ============================================================================
// tsf_pkg: shared types and constants of the tilemap stream fetch block
// Holds the field widths, memory geometry, operation codes and the command
// record that travels from the front end through the queue to the back end.
// ============================================================================
package tsf_pkg;

  // Map and window geometry
  localparam int MapSide       = 32;
  localparam int WindowWidth   = 31;
  localparam int WindowHeight  = 21;
  localparam int LayerCells    = 4096;
  localparam int TransDepth    = 1024;
  localparam int MaxWorldWidth = 256;
  localparam int GuardDepth    = MaxWorldWidth + 2;

  // Field widths
  localparam int OpW      = 3;
  localparam int IdxW     = 12;
  localparam int ValW     = 16;
  localparam int CoordW   = 16;
  localparam int MapIdxW  = 10;
  localparam int TileW    = 16;
  localparam int WidthW   = 9;
  localparam int HeightW  = 13;
  localparam int CountW   = 11;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;

  // Stream bus widths
  localparam int InDataW  = 64;
  localparam int InUserW  = 4;
  localparam int OutDataW = 32;

  // Derived widths
  localparam int SideBits = $clog2(MapSide);
  localparam int LayerAw  = $clog2(LayerCells);
  localparam int TransAw  = $clog2(TransDepth);
  localparam int GuardAw  = $clog2(GuardDepth);
  localparam int WinMax   = (WindowWidth > WindowHeight) ? WindowWidth : WindowHeight;
  localparam int WinCntW  = $clog2(WinMax + 1);
  localparam int AreaW    = WidthW + HeightW;
  localparam int CellW    = CoordW + WidthW + 2;

  // Queue depths
  localparam int CmdDepth = 4;
  localparam int OutDepth = 8;

  // Operation codes
  typedef enum logic [OpW-1:0] {
    OP_WR_LAYER = 3'd0,
    OP_WR_TRANS = 3'd1,
    OP_WR_GUARD = 3'd2,
    OP_FILL_COL = 3'd3,
    OP_FILL_ROW = 3'd4
  } op_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WORLD_WIDTH  = 2'd0,
    CFG_WORLD_HEIGHT = 2'd1,
    CFG_TRANS_COUNT  = 2'd2
  } cfg_reg_e;

  // Command handed from front to back end
  typedef struct packed {
    op_e                op;
    logic               sel;
    logic [IdxW-1:0]    idx;
    logic [ValW-1:0]    val;
    logic [CoordW-1:0]  x;
    logic [CoordW-1:0]  y;
  } cmd_t;

endpackage

>>> rtl/tsf_front.sv
// ============================================================================
// tsf_front: input stage and command classifier
// Takes stream transfers, decodes the operation, drops unknown operations and
// writes with out-of-range addresses, and holds one command for the queue.
// ============================================================================
module tsf_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [11:0] load_index, [27:12] load_value, [43:28] coord_x, [59:44] coord_y
  input  logic [tsf_pkg::InDataW-1:0] s_axis_tdata,
  // [2:0] operation, [3] layer_select
  input  logic [tsf_pkg::InUserW-1:0] s_axis_tuser,
  output tsf_pkg::cmd_t               cmd_o,
  output logic                        cmd_valid_o,
  input  logic                        cmd_ready_i
);
  import tsf_pkg::*;

  logic vld_q, vld_d;
  cmd_t cmd_q, dec;
  logic keep;
  logic accept;

  // Field unpack and classification
  always_comb begin
    dec.op  = op_e'(s_axis_tuser[OpW-1:0]);
    dec.sel = s_axis_tuser[OpW];
    dec.idx = s_axis_tdata[IdxW-1:0];
    dec.val = s_axis_tdata[IdxW+ValW-1:IdxW];
    dec.x   = s_axis_tdata[IdxW+ValW+CoordW-1:IdxW+ValW];
    dec.y   = s_axis_tdata[IdxW+ValW+2*CoordW-1:IdxW+ValW+CoordW];
    unique case (dec.op)
      OP_WR_LAYER: keep = 32'(dec.idx) < LayerCells;
      OP_WR_TRANS: keep = 32'(dec.idx) < TransDepth;
      OP_WR_GUARD: keep = 32'(dec.idx) < GuardDepth;
      OP_FILL_COL,
      OP_FILL_ROW: keep = 1'b1;
      default:     keep = 1'b0;
    endcase
  end

  assign s_axis_tready = !vld_q || cmd_ready_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    vld_d = vld_q;
    if (s_axis_tready) begin
      vld_d = s_axis_tvalid && keep;
    end
  end

  // Holding register toward the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= dec;
    end
  end

  assign cmd_o       = cmd_q;
  assign cmd_valid_o = vld_q;

endmodule

>>> rtl/tsf_cmd_queue.sv
// ============================================================================
// tsf_cmd_queue: command queue between front and back end
// Small register queue that lets the front end keep taking items while the
// back end walks a fill.
// ============================================================================
module tsf_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tsf_pkg::cmd_t push_cmd_i,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  output tsf_pkg::cmd_t pop_cmd_o,
  output logic          pop_valid_o,
  input  logic          pop_ready_i
);
  import tsf_pkg::*;

  localparam int PtrW = $clog2(CmdDepth);
  localparam int CntW = $clog2(CmdDepth + 1);

  cmd_t            mem_q [CmdDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(CmdDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cmd_o    = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(CmdDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(CmdDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CmdDepth))
    else $error("command queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(CmdDepth) && !pop) |=> cnt_q == CntW'(CmdDepth))
    else $error("command queue lost its fill level");
  a_cnt_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("command queue count did not follow a push");
`endif

endmodule

>>> rtl/tsf_back.sv
// ============================================================================
// tsf_back: table memories, fill walker, fetch pipeline and result queue
// Executes table writes and walks fills one cell a cycle while the result queue
// has credit, through a four stage fetch pipeline into an eight-entry result queue.
// ============================================================================
module tsf_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tsf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tsf_pkg::CfgDataW-1:0] cfg_data_i,
  input  tsf_pkg::cmd_t                cmd_i,
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [9:0] map_index, [25:10] tile_entry, [31:26] zero
  output logic [tsf_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast
);
  import tsf_pkg::*;

  localparam int OutPtrW = $clog2(OutDepth);
  localparam int OutCntW = $clog2(OutDepth + 1);
  localparam int GiW     = WidthW + 1;

  typedef enum logic {ST_IDLE, ST_WALK} state_e;
  typedef enum logic [1:0] {SRC_ZERO, SRC_LAYER, SRC_GUARD} src_e;

  typedef struct packed {
    logic               last;
    logic [TileW-1:0]   tile;
    logic [MapIdxW-1:0] slot;
  } out_t;

  // ---------------- configuration ----------------
  logic [WidthW-1:0]  w_q;
  logic [HeightW-1:0] h_q;
  logic [CountW-1:0]  tc_q;
  logic [AreaW-1:0]   n_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= WidthW'(1);
      h_q  <= HeightW'(1);
      tc_q <= '0;
      n_q  <= AreaW'(1);
    end else begin
      n_q <= AreaW'(w_q) * AreaW'(h_q);
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_WORLD_WIDTH:  w_q  <= cfg_data_i[WidthW-1:0];
          CFG_WORLD_HEIGHT: h_q  <= cfg_data_i[HeightW-1:0];
          CFG_TRANS_COUNT:  tc_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- memories ----------------
  logic [TileW-1:0] layer_mem [2][LayerCells];
  logic [TileW-1:0] guard_mem [2][GuardDepth];
  logic [TileW-1:0] trans_mem [TransDepth];

  // ---------------- walker ----------------
  state_e             st_q;
  logic [CoordW-1:0]  wx_q, wy_q;
  logic               wsel_q, wcol_q;
  logic [WinCntW-1:0] wk_q, total;
  logic               walk_last, issue, credit_ok, pop;
  logic               v1_q, v2_q, v3_q, v4_q;
  logic [3:0]         pv;
  logic [OutCntW-1:0] out_cnt_q, out_cnt_d;

  assign pv          = {v4_q, v3_q, v2_q, v1_q};
  assign cmd_ready_o = (st_q == ST_IDLE) && (pv == '0);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign total       = wcol_q ? WinCntW'(WindowHeight) : WinCntW'(WindowWidth);
  assign walk_last   = wk_q == total - WinCntW'(1);
  assign credit_ok   = (int'(out_cnt_q) + $countones(pv)) < OutDepth;
  assign issue       = (st_q == ST_WALK) && credit_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      wk_q   <= '0;
      wx_q   <= '0;
      wy_q   <= '0;
      wsel_q <= 1'b0;
      wcol_q <= 1'b0;
    end else begin
      unique case (st_q)
        ST_IDLE: begin
          if (pop && (cmd_i.op == OP_FILL_COL || cmd_i.op == OP_FILL_ROW)) begin
            st_q   <= ST_WALK;
            wk_q   <= '0;
            wx_q   <= cmd_i.x;
            wy_q   <= cmd_i.y;
            wsel_q <= cmd_i.sel;
            wcol_q <= cmd_i.op == OP_FILL_COL;
          end
        end
        ST_WALK: begin
          if (issue) begin
            wk_q <= wk_q + WinCntW'(1);
            if (wcol_q) begin
              wy_q <= wy_q + CoordW'(1);
            end else begin
              wx_q <= wx_q + CoordW'(1);
            end
            if (walk_last) begin
              st_q <= ST_IDLE;
            end
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // Table writes, taken only while the pipeline is empty
  always_ff @(posedge clk_i) begin
    if (pop && cmd_i.op == OP_WR_LAYER) begin
      layer_mem[cmd_i.sel][cmd_i.idx[LayerAw-1:0]] <= cmd_i.val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && cmd_i.op == OP_WR_GUARD) begin
      guard_mem[cmd_i.sel][cmd_i.idx[GuardAw-1:0]] <= cmd_i.val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && cmd_i.op == OP_WR_TRANS) begin
      trans_mem[cmd_i.idx[TransAw-1:0]] <= cmd_i.val;
    end
  end

  // ---------------- stage 1: linear cell and ring slot ----------------
  logic signed [CellW-1:0] y_ext, x_ext, w_ext, cell_d;
  logic [2*SideBits-1:0]   slot_wide;
  logic signed [CellW-1:0] c1_q;
  logic [MapIdxW-1:0]      s1_q, s2_q, s3_q, s4_q;
  logic                    l1_q, l2_q, l3_q, l4_q;
  logic                    e1_q, e2_q;

  always_comb begin
    y_ext     = CellW'($signed(wy_q));
    x_ext     = CellW'($signed(wx_q));
    w_ext     = $signed(CellW'(w_q));
    cell_d    = y_ext * w_ext + x_ext;
    slot_wide = {wy_q[SideBits-1:0], wx_q[SideBits-1:0]};
  end

  always_ff @(posedge clk_i) begin
    c1_q <= cell_d;
    s1_q <= MapIdxW'(slot_wide);
    l1_q <= walk_last;
    e1_q <= wsel_q;
  end

  // ---------------- stage 2: range classification ----------------
  logic signed [CellW-1:0] n_ext, d2_q;
  logic                    neg2_q, m12_q, ltn2_q, ltcap2_q;
  logic [LayerAw-1:0]      a2_q;

  assign n_ext = $signed(CellW'(n_q));

  always_ff @(posedge clk_i) begin
    d2_q     <= c1_q - n_ext;
    neg2_q   <= c1_q[CellW-1];
    m12_q    <= c1_q == '1;
    ltn2_q   <= c1_q < n_ext;
    ltcap2_q <= c1_q < $signed(CellW'(LayerCells));
    a2_q     <= c1_q[LayerAw-1:0];
    s2_q     <= s1_q;
    l2_q     <= l1_q;
    e2_q     <= e1_q;
  end

  // ---------------- stage 3: layer and guard reads ----------------
  logic [GiW-1:0]     gi_wide;
  logic [GuardAw-1:0] gaddr;
  logic               in_layer, in_guard;
  src_e               src2, k3_q;
  logic [TileW-1:0]   lay_rd_q, guard_rd_q;

  always_comb begin
    gi_wide  = GiW'(d2_q[WidthW-1:0]) + GiW'(1);
    in_layer = !neg2_q && ltn2_q && ltcap2_q;
    in_guard = m12_q ||
               (!neg2_q && !ltn2_q && (d2_q <= w_ext) && (32'(gi_wide) < GuardDepth));
    gaddr    = m12_q ? '0 : gi_wide[GuardAw-1:0];
    if (in_layer) begin
      src2 = SRC_LAYER;
    end else if (in_guard) begin
      src2 = SRC_GUARD;
    end else begin
      src2 = SRC_ZERO;
    end
  end

  always_ff @(posedge clk_i) begin
    lay_rd_q   <= layer_mem[e2_q][a2_q];
    guard_rd_q <= guard_mem[e2_q][gaddr];
    k3_q       <= src2;
    s3_q       <= s2_q;
    l3_q       <= l2_q;
  end

  // ---------------- stage 4: translation read ----------------
  logic             id_ok, use_t4_q, use_g4_q;
  logic [TileW-1:0] trans_rd_q, g4_q, tile;

  assign id_ok = (32'(lay_rd_q) < 32'(tc_q)) && (32'(lay_rd_q) < TransDepth);

  always_ff @(posedge clk_i) begin
    trans_rd_q <= trans_mem[lay_rd_q[TransAw-1:0]];
    use_t4_q   <= (k3_q == SRC_LAYER) && id_ok;
    use_g4_q   <= k3_q == SRC_GUARD;
    g4_q       <= guard_rd_q;
    s4_q       <= s3_q;
    l4_q       <= l3_q;
  end

  assign tile = use_t4_q ? trans_rd_q : (use_g4_q ? g4_q : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // ---------------- result queue ----------------
  out_t               omem_q [OutDepth];
  out_t               head;
  logic [OutPtrW-1:0] owr_q, ord_q;
  logic               opush, opop;

  assign opush         = v4_q;
  assign m_axis_tvalid = out_cnt_q != '0;
  assign opop          = m_axis_tvalid && m_axis_tready;
  assign head          = omem_q[ord_q];
  assign m_axis_tdata  = OutDataW'({head.tile, head.slot});
  assign m_axis_tlast  = head.last;

  always_comb begin
    out_cnt_d = out_cnt_q;
    if (opush && !opop) begin
      out_cnt_d = out_cnt_q + OutCntW'(1);
    end else if (opop && !opush) begin
      out_cnt_d = out_cnt_q - OutCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q     <= '0;
      ord_q     <= '0;
      out_cnt_q <= '0;
    end else begin
      out_cnt_q <= out_cnt_d;
      if (opush) begin
        owr_q <= (owr_q == OutPtrW'(OutDepth - 1)) ? '0 : owr_q + OutPtrW'(1);
      end
      if (opop) begin
        ord_q <= (ord_q == OutPtrW'(OutDepth - 1)) ? '0 : ord_q + OutPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      omem_q[owr_q] <= '{last: l4_q, tile: tile, slot: s4_q};
    end
  end

`ifndef NO_ASSERTIONS
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(out_cnt_q) + $countones(pv)) <= OutDepth)
    else $error("result queue credit exceeded");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (pv == '0 && st_q == ST_IDLE))
    else $error("command taken while a fill is in flight");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && walk_last) |=> st_q == ST_IDLE)
    else $error("walker did not stop after the last cell");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    opush |-> (out_cnt_q < OutCntW'(OutDepth) || opop))
    else $error("result queue overflow");
`endif

endmodule

>>> rtl/tilemap_stream_fetch.sv
// ============================================================================
// tilemap_stream_fetch: scrolling tilemap fetch into a ring-buffer tile map
// Loads two tile layers, two guard arrays and a translation table, and turns
// column and row fill items into one map write per window cell.
// ============================================================================
//
//  channel   direction  payload                                   handshake
//  s_axis    in         tuser: operation, layer_select;           tvalid/tready
//                       tdata: load_index, load_value, x, y
//  m_axis    out        tdata: map_index, tile_entry; tlast       tvalid/tready
//  cfg       in         cfg_index_i, cfg_data_i                   valid/ready
//
//  A table write passes the front-end holding register and the command queue
//  and waits in the queue while a fill is in flight. A fill walks one cell per
//  cycle while the result queue has credit (21 cells for a column, 31 for a
//  row) through a four-stage fetch pipeline; the next command starts once it drains.
//  Result backpressure throttles the walker through a credit against the
//  eight-entry result queue; the input keeps taking items until the
//  four-entry command queue and the front-end holding register are full.
//  Reset clears control state only; tables hold nothing until written.
//
module tilemap_stream_fetch (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [11:0] load_index, [27:12] load_value, [43:28] coord_x, [59:44] coord_y
  input  logic [tsf_pkg::InDataW-1:0]  s_axis_tdata,
  // [2:0] operation, [3] layer_select
  input  logic [tsf_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [9:0] map_index, [25:10] tile_entry, [31:26] zero
  output logic [tsf_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tsf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tsf_pkg::CfgDataW-1:0] cfg_data_i
);
  import tsf_pkg::*;

  cmd_t fr_cmd, q_cmd;
  logic fr_valid, fr_ready, q_valid, q_ready;

  // Front end: take and classify items
  tsf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_o         (fr_cmd),
    .cmd_valid_o   (fr_valid),
    .cmd_ready_i   (fr_ready)
  );

  // Decoupling queue
  tsf_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cmd_i   (fr_cmd),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .pop_cmd_o    (q_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready)
  );

  // Back end: tables, walker, fetch pipeline
  tsf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (q_cmd),
    .cmd_valid_i   (q_valid),
    .cmd_ready_o   (q_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for the tilemap stream fetch block
// Loads layers, guards and the translation table through the input stream,
// sweeps the level geometry through the register port and checks every map
// write of each column and row fill against a behavioral prediction kept in
// the bench. Both stream sides idle and stall at random.
// ============================================================================
module tb;
  import tsf_pkg::*;

  // Opcodes that the block ignores
  localparam logic [OpW-1:0] OpRsvdFirst = 3'd5;
  localparam logic [OpW-1:0] OpRsvdLast  = 3'd7;

  localparam int DrainCycles = 40;
  localparam int ItemBudget  = 350;
  localparam int NSteps      = 26;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic              sel;
    logic [IdxW-1:0]   idx;
    logic [ValW-1:0]   val;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } fetch_item_t;

  typedef struct packed {
    logic [MapIdxW-1:0] slot;
    logic [TileW-1:0]   tile;
    logic               last;
  } map_wr_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;
  typedef enum {SRC_NONE, SRC_LAYER, SRC_FRINGE} src_e;

  // Directed row; for ROW_REG, idx holds the register and val the data.
  // tile_exp >= 0 pins every tile of a fill to that value.
  typedef struct packed {
    row_kind_e         kind;
    logic [OpW-1:0]    op;
    logic              sel;
    logic [IdxW-1:0]   idx;
    logic [ValW-1:0]   val;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    int                tile_exp;
  } step_t;

  step_t steps [NSteps] = '{
    // reset geometry: fills far from the level, wrapping coordinates
    '{ROW_ITEM, OP_FILL_ROW, 1'b0, '0, '0, 16'h8000, 16'h8000, 0},
    '{ROW_ITEM, OP_FILL_COL, 1'b1, '0, '0, 16'd1000, 16'd32760, 0},
    '{ROW_ITEM, OP_FILL_ROW, 1'b0, '0, '0, 16'd32767, 16'd0, 0},
    // ignored opcodes
    '{ROW_ITEM, OpRsvdFirst, 1'b0, 12'h5A5, 16'h1234, '0, '0, -1},
    '{ROW_ITEM, OpRsvdLast, 1'b1, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, -1},
    // writes out of range, then extremes of index and data
    '{ROW_ITEM, OP_WR_TRANS, 1'b0, 12'hFFF, 16'hFFFF, '0, '0, -1},
    '{ROW_ITEM, OP_WR_GUARD, 1'b1, 12'd258, 16'hBEEF, '0, '0, -1},
    '{ROW_ITEM, OP_WR_GUARD, 1'b0, 12'd0, 16'hFFFF, '0, '0, -1},
    '{ROW_ITEM, OP_WR_GUARD, 1'b1, 12'd257, 16'h0000, '0, '0, -1},
    '{ROW_ITEM, OP_WR_LAYER, 1'b1, 12'hFFF, 16'hFFFF, '0, '0, -1},
    '{ROW_ITEM, OP_WR_LAYER, 1'b0, 12'd0, 16'h0000, '0, '0, -1},
    '{ROW_ITEM, OP_WR_TRANS, 1'b0, 12'd0, 16'hFFFF, '0, '0, -1},
    '{ROW_ITEM, OP_WR_TRANS, 1'b0, 12'd1023, 16'h8001, '0, '0, -1},
    // small level: top guard, layer, bottom guards
    '{ROW_REG, '0, 1'b0, CFG_WORLD_WIDTH, 16'd4, '0, '0, -1},
    '{ROW_REG, '0, 1'b0, CFG_WORLD_HEIGHT, 16'd3, '0, '0, -1},
    '{ROW_REG, '0, 1'b0, CFG_TRANS_COUNT, 16'd2047, '0, '0, -1},
    '{ROW_ITEM, OP_FILL_COL, 1'b0, '0, '0, 16'd3, -16'sd2, -1},
    '{ROW_ITEM, OP_FILL_ROW, 1'b1, '0, '0, -16'sd2, 16'd3, -1},
    // zero width: the level is empty
    '{ROW_REG, '0, 1'b0, CFG_WORLD_WIDTH, 16'd0, '0, '0, -1},
    '{ROW_ITEM, OP_FILL_ROW, 1'b1, '0, '0, -16'sd3, 16'd5, -1},
    // full layer capacity, guard array up to its last entry
    '{ROW_REG, '0, 1'b0, CFG_WORLD_WIDTH, 16'd256, '0, '0, -1},
    '{ROW_REG, '0, 1'b0, CFG_WORLD_HEIGHT, 16'd16, '0, '0, -1},
    '{ROW_ITEM, OP_FILL_COL, 1'b1, '0, '0, 16'd255, -16'sd2, -1},
    '{ROW_ITEM, OP_FILL_ROW, 1'b0, '0, '0, 16'd250, 16'd16, -1},
    // no valid translations
    '{ROW_REG, '0, 1'b0, CFG_TRANS_COUNT, 16'd0, '0, '0, -1},
    '{ROW_ITEM, OP_FILL_COL, 1'b0, '0, '0, 16'd0, 16'd0, -1}
  };

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [InUserW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // Predicted block state
  int                  lvl_w    = 1;
  int                  lvl_h    = 1;
  int                  xlat_cnt = 0;
  logic [TileW-1:0]    src_tiles    [2][LayerCells];
  bit                  src_known    [2][LayerCells];
  logic [TileW-1:0]    xlat_tbl     [TransDepth];
  bit                  xlat_known   [TransDepth];
  logic [TileW-1:0]    fringe_tiles [2][GuardDepth];
  bit                  fringe_known [2][GuardDepth];

  map_wr_t             slot_writes_due [$];
  int                  mismatches = 0;
  int                  items_sent = 0;
  bit                  steady     = 1'b0;

  tilemap_stream_fetch dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(20_000_000);
    $display("tb: failure");
    $finish;
  end

  // Idle cycles before a transfer; none in steady stretches
  function automatic int pause_len();
    return steady ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic int span_of(logic [OpW-1:0] op);
    return (op == OP_FILL_COL) ? WindowHeight : WindowWidth;
  endfunction

  // World coordinates of step k of a fill, wrapping at 16 bits
  function automatic void walk_cell(fetch_item_t it, int k,
                                    output logic [CoordW-1:0] cx,
                                    output logic [CoordW-1:0] cy);
    cx = it.x;
    cy = it.y;
    if (it.op == OP_FILL_COL) cy = it.y + 16'(k);
    else cx = it.x + 16'(k);
  endfunction

  // Which store a world cell reads, and at which address
  function automatic src_e locate_cell(logic [CoordW-1:0] cx, logic [CoordW-1:0] cy,
                                       output int addr);
    longint w;
    longint n;
    longint c;
    w = lvl_w;
    n = w * lvl_h;
    c = longint'($signed(cy)) * w + longint'($signed(cx));
    addr = 0;
    if (c >= 0 && c < n) begin
      if (c >= LayerCells) return SRC_NONE;
      addr = int'(c);
      return SRC_LAYER;
    end
    if (c < -1 || c > n + w) return SRC_NONE;
    addr = (c < 0) ? 0 : int'(c - n + 1);
    return (addr >= GuardDepth) ? SRC_NONE : SRC_FRINGE;
  endfunction

  function automatic bit xlat_hit(logic [TileW-1:0] id);
    return (int'(id) < xlat_cnt) && (int'(id) < TransDepth);
  endfunction

  function automatic logic [TileW-1:0] tile_at(logic sel, logic [CoordW-1:0] cx,
                                               logic [CoordW-1:0] cy);
    int               a;
    logic [TileW-1:0] id;
    case (locate_cell(cx, cy, a))
      SRC_LAYER: begin
        id = src_tiles[sel][a];
        return xlat_hit(id) ? xlat_tbl[id[TransAw-1:0]] : '0;
      end
      SRC_FRINGE: return fringe_tiles[sel][a];
      default: return '0;
    endcase
  endfunction

  // Update the prediction for one accepted item
  function automatic void apply_item(fetch_item_t it, int tile_exp);
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    map_wr_t           wr;
    case (it.op)
      OP_WR_LAYER: begin
        src_tiles[it.sel][it.idx] = it.val;
        src_known[it.sel][it.idx] = 1'b1;
      end
      OP_WR_TRANS: begin
        if (it.idx < TransDepth) begin
          xlat_tbl[it.idx]   = it.val;
          xlat_known[it.idx] = 1'b1;
        end
      end
      OP_WR_GUARD: begin
        if (it.idx < GuardDepth) begin
          fringe_tiles[it.sel][it.idx] = it.val;
          fringe_known[it.sel][it.idx] = 1'b1;
        end
      end
      OP_FILL_COL, OP_FILL_ROW: begin
        for (int k = 0; k < span_of(it.op); k++) begin
          walk_cell(it, k, cx, cy);
          wr.slot = MapIdxW'((int'(cy) % MapSide) * MapSide + int'(cx) % MapSide);
          wr.tile = (tile_exp >= 0) ? TileW'(tile_exp) : tile_at(it.sel, cx, cy);
          wr.last = (k == span_of(it.op) - 1);
          slot_writes_due.push_back(wr);
        end
      end
      default: ;
    endcase
  endfunction

  // One input transfer; valid stays high for a back-to-back follower
  task automatic send_item(fetch_item_t it, int tile_exp);
    int gap;
    gap = pause_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({it.y, it.x, it.val, it.idx});
    s_axis_tuser  <= {it.sel, it.op};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    items_sent++;
    apply_item(it, tile_exp);
  endtask

  task automatic push_write(logic [OpW-1:0] op, logic sel, int idx, logic [ValW-1:0] val);
    fetch_item_t it;
    it.op  = op;
    it.sel = sel;
    it.idx = idx[IdxW-1:0];
    it.val = val;
    it.x   = 16'($urandom);
    it.y   = 16'($urandom);
    send_item(it, -1);
  endtask

  // Load every entry a fill will read that has not been written yet
  task automatic prime_fill(fetch_item_t it);
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [TileW-1:0]  id;
    int                a;
    for (int k = 0; k < span_of(it.op); k++) begin
      walk_cell(it, k, cx, cy);
      case (locate_cell(cx, cy, a))
        SRC_LAYER: begin
          // ids mostly inside the table, now and then anything
          if (!src_known[it.sel][a])
            push_write(OP_WR_LAYER, it.sel, a, ($urandom_range(0, 7) == 0) ?
                       16'($urandom) : 16'($urandom_range(0, 1100)));
          id = src_tiles[it.sel][a];
          if (xlat_hit(id) && !xlat_known[id[TransAw-1:0]])
            push_write(OP_WR_TRANS, it.sel, int'(id), 16'($urandom));
        end
        SRC_FRINGE: begin
          if (!fringe_known[it.sel][a]) push_write(OP_WR_GUARD, it.sel, a, 16'($urandom));
        end
        default: ;
      endcase
    end
  endtask

  // Stop input, let expected writes arrive, then let queued table writes land
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (slot_writes_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e which, logic [CfgDataW-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    case (which)
      CFG_WORLD_WIDTH:  lvl_w    = int'(data[WidthW-1:0]);
      CFG_WORLD_HEIGHT: lvl_h    = int'(data[HeightW-1:0]);
      CFG_TRANS_COUNT:  xlat_cnt = int'(data[CountW-1:0]);
      default: ;
    endcase
  endtask

  // Result side: random stalls, compare each transfer with the oldest prediction
  initial begin : result_check
    map_wr_t want;
    map_wr_t got;
    int      stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = pause_len();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      got.slot = m_axis_tdata[MapIdxW-1:0];
      got.tile = m_axis_tdata[MapIdxW +: TileW];
      got.last = m_axis_tlast;
      if (slot_writes_due.size() == 0) begin
        $display("[%0t] unexpected map write: expected none, got index %0d tile %h last %b",
                 $time, got.slot, got.tile, got.last);
        mismatches++;
      end else begin
        want = slot_writes_due.pop_front();
        if (got.slot !== want.slot) begin
          $display("[%0t] map_index: expected %0d, got %0d", $time, want.slot, got.slot);
          mismatches++;
        end
        if (got.tile !== want.tile) begin
          $display("[%0t] tile_entry at %0d: expected %h, got %h",
                   $time, want.slot, want.tile, got.tile);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $display("[%0t] last at %0d: expected %b, got %b",
                   $time, want.slot, want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random phases
  initial begin : stimulus
    fetch_item_t it;
    int          rnd;
    int          mask;
    int          burst;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (steps[i]) begin
      if (steps[i].kind == ROW_REG) begin
        write_reg(cfg_reg_e'(steps[i].idx[CfgIdxW-1:0]), steps[i].val[CfgDataW-1:0]);
      end else begin
        it = '{steps[i].op, steps[i].sel, steps[i].idx, steps[i].val, steps[i].x, steps[i].y};
        if (it.op == OP_FILL_COL || it.op == OP_FILL_ROW) prime_fill(it);
        send_item(it, steps[i].tile_exp);
      end
    end

    // random phases, each after one or more register writes; loads count toward the budget
    while (items_sent < ItemBudget) begin
      steady = 1'b0;
      mask = $urandom_range(1, 7);
      if (mask[0]) begin
        case ($urandom_range(0, 5))
          0: write_reg(CFG_WORLD_WIDTH, 13'd1);
          1: write_reg(CFG_WORLD_WIDTH, 13'd0);
          2: write_reg(CFG_WORLD_WIDTH, 13'd511);
          3: write_reg(CFG_WORLD_WIDTH, 13'd256);
          default: write_reg(CFG_WORLD_WIDTH, 13'($urandom_range(2, 64)));
        endcase
      end
      if (mask[1]) begin
        case ($urandom_range(0, 4))
          0: write_reg(CFG_WORLD_HEIGHT, 13'd1);
          1: write_reg(CFG_WORLD_HEIGHT, 13'd8191);
          2: write_reg(CFG_WORLD_HEIGHT, 13'((lvl_w > 0) ? LayerCells / lvl_w : 64));
          default: write_reg(CFG_WORLD_HEIGHT, 13'($urandom_range(1, 64)));
        endcase
      end
      if (mask[2]) begin
        case ($urandom_range(0, 4))
          0: write_reg(CFG_TRANS_COUNT, 13'd0);
          1: write_reg(CFG_TRANS_COUNT, 13'd2047);
          2: write_reg(CFG_TRANS_COUNT, 13'd1024);
          default: write_reg(CFG_TRANS_COUNT, 13'($urandom_range(1, 1100)));
        endcase
      end
      steady = ($urandom_range(0, 3) == 0);
      burst  = $urandom_range(10, 40);
      for (int j = 0; j < burst && items_sent < ItemBudget; j++) begin
        rnd    = $urandom_range(0, 99);
        it.sel = 1'($urandom);
        it.idx = 12'($urandom);
        it.val = 16'($urandom);
        it.x   = 16'($urandom);
        it.y   = 16'($urandom);
        if (rnd < 27) begin
          // column fill around the level, reaching both guard zones
          it.op = OP_FILL_COL;
          it.x  = 16'(int'($urandom_range(0, lvl_w + 2)) - 2);
          it.y  = 16'(int'($urandom_range(0, lvl_h + 24)) - 23);
        end else if (rnd < 55) begin
          it.op = OP_FILL_ROW;
          it.x  = 16'(int'($urandom_range(0, lvl_w + 33)) - 32);
          it.y  = 16'(int'($urandom_range(0, lvl_h + 2)) - 2);
        end else if (rnd < 65) begin
          // fill anywhere in coordinate space
          it.op = (rnd < 60) ? OP_FILL_COL : OP_FILL_ROW;
        end else if (rnd < 93) begin
          case (rnd % 3)
            0: it.op = OP_WR_LAYER;
            1: begin
              it.op = OP_WR_TRANS;
              if ($urandom_range(0, 3) != 0) it.idx = 12'($urandom_range(0, TransDepth - 1));
            end
            default: begin
              it.op = OP_WR_GUARD;
              if ($urandom_range(0, 3) != 0) it.idx = 12'($urandom_range(0, GuardDepth - 1));
            end
          endcase
        end else begin
          it.op = 3'($urandom_range(OpRsvdFirst, OpRsvdLast));
        end
        if (it.op == OP_FILL_COL || it.op == OP_FILL_ROW) prime_fill(it);
        send_item(it, -1);
      end
    end

    // drain and report
    steady = 1'b0;
    settle();
    if (slot_writes_due.size() != 0) mismatches++;
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
